// File: hdl/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg: shared definitions for the matrix line rotator
// Default sizes, register indexes, operation and status codes, and the
// widths of the stream and configuration ports.
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam int unsigned MAX_ROWS_DEF   = 16;
  localparam int unsigned MAX_COLS_DEF   = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Stream payload widths; the data widths are padded to whole bytes.
  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned S_USER_W = 2;
  localparam int unsigned M_DATA_W = 32;
  localparam int unsigned M_USER_W = 2;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS = 1'd1;

  localparam logic [CFG_DATA_W-1:0] NUM_ROWS_RESET = 5'd16;
  localparam logic [CFG_DATA_W-1:0] NUM_COLS_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_WRITE_CELL = 2'd0,
    OP_READ_CELL  = 2'd1,
    OP_ROTATE_ROW = 2'd2,
    OP_ROTATE_COL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_LINE  = 2'd1,
    STATUS_BAD_CELL  = 2'd2,
    STATUS_RESERVED  = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_TURN  = 6'b000100,
    ST_CELL  = 6'b001000,
    ST_FETCH = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

// File: hdl/matrix_line_rotator.sv
// ----------------------------------------------------------------------------
// matrix_line_rotator: matrix store with circular row and column rotation
// Holds a matrix of signed cells in a single-port store and runs one
// operation per input beat: write a cell, read a cell, rotate a row or
// rotate a column.
// ----------------------------------------------------------------------------
// Usage:
//   An operation enters as one beat on the s_ group (kind in s_tuser) and
//   leaves exactly one result beat on the m_ group (status in m_tuser, cell
//   value in m_tdata). The sizes in use are to be set through the cfg_ port
//   only while the block is idle; the block itself does not enforce this.
//   Values outside 1..MAX count as the nearest bound. After acceptance, a
//   rejected operation goes straight to the done state; a cell write passes
//   through the cell state, a cell read through the cell and fetch states,
//   and a rotation through the load pass and then the turn pass.
//   A rotation is bounded by the single store port: every cell of the line
//   is read once into the line buffer and written back once, one per cycle.
//   The shift is reduced modulo n by a bit-serial remainder unit that runs
//   alongside the read pass and sets the time of short lines.
//   s_tready rises at the edge that loads the result register, and the next
//   beat is taken while the block is idle. One finished result may wait
//   while the next beat is taken. If the receiver stalls with a result still
//   held, the next result waits until that one is taken. Reset clears the
//   control state and sets both sizes to 16; the cell contents are undefined
//   until written.
// ----------------------------------------------------------------------------
module matrix_line_rotator
  import mlr_pkg::*;
#(
  parameter int unsigned MAX_ROWS   = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS   = MAX_COLS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input beat.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [4:0] line_index, [5] direction, [13:6] shift_amount, [17:14] cell_row,
  // [21:18] cell_col, [53:22] write_value, [55:54] zero
  input  logic [S_DATA_W-1:0]    s_tdata,
  // [1:0] op
  input  logic [S_USER_W-1:0]    s_tuser,
  // Result beat.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [31:0] read_value
  output logic [M_DATA_W-1:0]    m_tdata,
  // [1:0] status
  output logic [M_USER_W-1:0]    m_tuser,
  // Configuration writes.
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned LBUF_DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned RW         = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW         = $clog2(MAX_COLS + 1);
  localparam int unsigned LW         = $clog2(LBUF_DEPTH + 1);
  localparam int unsigned IW         = $clog2(LBUF_DEPTH);
  localparam int unsigned DEPTH      = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW         = $clog2(DEPTH);

  // Input field unpacking.
  logic [4:0]  in_line;
  logic        in_dir;
  logic [7:0]  in_shift;
  logic [3:0]  in_row;
  logic [3:0]  in_col;
  logic [31:0] in_value;
  op_t         in_op;

  assign in_line  = s_tdata[4:0];
  assign in_dir   = s_tdata[5];
  assign in_shift = s_tdata[13:6];
  assign in_row   = s_tdata[17:14];
  assign in_col   = s_tdata[21:18];
  assign in_value = s_tdata[53:22];
  assign in_op    = op_t'(s_tuser[1:0]);

  // Configuration registers and the sizes they stand for.
  logic [CFG_DATA_W-1:0] num_rows;
  logic [CFG_DATA_W-1:0] num_cols;
  logic [RW-1:0]         eff_rows;
  logic [CW-1:0]         eff_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= NUM_ROWS_RESET;
      num_cols <= NUM_COLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_ROWS: num_rows <= cfg_data;
        REG_NUM_COLS: num_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_rows == '0) begin
      eff_rows = RW'(1);
    end else if (32'(num_rows) > MAX_ROWS) begin
      eff_rows = RW'(MAX_ROWS);
    end else begin
      eff_rows = RW'(num_rows);
    end
    if (num_cols == '0) begin
      eff_cols = CW'(1);
    end else if (32'(num_cols) > MAX_COLS) begin
      eff_cols = CW'(MAX_COLS);
    end else begin
      eff_cols = CW'(num_cols);
    end
  end

  // Checks and addresses decoded from the input beat.
  logic          cell_ok;
  logic          row_line_ok;
  logic          col_line_ok;
  logic [4:0]    line_m1;
  logic [AW-1:0] cell_addr;
  logic [AW-1:0] row_base;
  logic [AW-1:0] col_base;

  assign cell_ok     = (8'(in_row) < 8'(eff_rows)) && (8'(in_col) < 8'(eff_cols));
  assign row_line_ok = (in_line != '0) && (8'(in_line) <= 8'(eff_rows));
  assign col_line_ok = (in_line != '0) && (8'(in_line) <= 8'(eff_cols));
  assign line_m1     = in_line - 5'd1;
  assign cell_addr   = AW'(32'(in_row) * MAX_COLS + 32'(in_col));
  assign row_base    = AW'(32'(line_m1) * MAX_COLS);
  assign col_base    = AW'(line_m1);

  // Sequencer registers.
  state_t                state;
  state_t                state_next;
  logic                  is_write;
  logic                  dir;
  logic [AW-1:0]         stride;
  logic [AW-1:0]         base;
  logic [AW-1:0]         addr;
  logic [LW-1:0]         len;
  logic [LW-1:0]         k;
  logic [IW-1:0]         src;
  logic [VALUE_BITS-1:0] wv;
  status_t               res_status;
  logic [31:0]           res_value;

  // Bit-serial remainder unit: shift mod len, one bit per cycle.
  logic [3:0]  mod_cnt;
  logic [7:0]  mod_sh;
  logic [LW-1:0] rem;
  logic [LW:0]   rem_sh;
  logic          mod_done;

  assign rem_sh   = {rem, mod_sh[7]};
  assign mod_done = (mod_cnt == '0);

  // Pipe stages between the store, the line buffer and back.
  logic                  p1_v;
  logic [IW-1:0]         p1_idx;
  logic                  p2_v;
  logic [AW-1:0]         p2_addr;
  logic [VALUE_BITS-1:0] mem_rdata;
  logic [VALUE_BITS-1:0] lbuf_rdata;

  logic                  accept;
  logic                  k_live;
  logic                  out_free;
  logic [IW-1:0]         src0;
  logic [IW-1:0]         src_inc;
  logic signed [VALUE_BITS+31:0] wv_wide;
  logic signed [VALUE_BITS+31:0] rd_wide;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign k_live   = (k < len);
  assign out_free = !m_tvalid || m_tready;
  assign wv_wide  = (VALUE_BITS + 32)'(signed'(in_value));
  assign rd_wide  = (VALUE_BITS + 32)'(signed'(mem_rdata));

  // Right or down takes the old cell (k - s) mod n, so the walk starts at n - s.
  always_comb begin
    if (dir) begin
      src0 = IW'(rem);
    end else if (rem == '0) begin
      src0 = '0;
    end else begin
      src0 = IW'(len - rem);
    end
    if (LW'(src) + LW'(1) == len) begin
      src_inc = '0;
    end else begin
      src_inc = src + IW'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_WRITE_CELL, OP_READ_CELL: state_next = cell_ok ? ST_CELL : ST_DONE;
            OP_ROTATE_ROW: state_next = row_line_ok ? ST_LOAD : ST_DONE;
            OP_ROTATE_COL: state_next = col_line_ok ? ST_LOAD : ST_DONE;
          endcase
        end
      end
      ST_LOAD:  if (!k_live && mod_done) state_next = ST_TURN;
      ST_TURN:  if (!k_live) state_next = ST_DONE;
      ST_CELL:  state_next = is_write ? ST_DONE : ST_FETCH;
      ST_FETCH: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      p1_v     <= 1'b0;
      p2_v     <= 1'b0;
      mod_cnt  <= '0;
    end else begin
      state <= state_next;
      p1_v  <= (state == ST_LOAD) && k_live;
      p2_v  <= (state == ST_TURN) && k_live;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        mod_cnt <= 4'd8;
      end else if (!mod_done) begin
        mod_cnt <= mod_cnt - 4'd1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    p1_idx  <= IW'(k);
    p2_addr <= addr;
    if (accept) begin
      mod_sh <= in_shift;
      rem    <= '0;
    end else if (!mod_done) begin
      mod_sh <= {mod_sh[6:0], 1'b0};
      if (rem_sh >= {1'b0, len}) begin
        rem <= LW'(rem_sh - {1'b0, len});
      end else begin
        rem <= LW'(rem_sh);
      end
    end
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          is_write   <= (in_op == OP_WRITE_CELL);
          dir        <= in_dir;
          wv         <= VALUE_BITS'(wv_wide);
          res_value  <= '0;
          res_status <= STATUS_OK;
          k          <= '0;
          unique case (in_op)
            OP_WRITE_CELL, OP_READ_CELL: begin
              addr <= cell_addr;
              if (!cell_ok) res_status <= STATUS_BAD_CELL;
            end
            OP_ROTATE_ROW: begin
              addr   <= row_base;
              base   <= row_base;
              stride <= AW'(1);
              len    <= LW'(eff_cols);
              if (!row_line_ok) res_status <= STATUS_BAD_LINE;
            end
            OP_ROTATE_COL: begin
              addr   <= col_base;
              base   <= col_base;
              stride <= AW'(MAX_COLS);
              len    <= LW'(eff_rows);
              if (!col_line_ok) res_status <= STATUS_BAD_LINE;
            end
          endcase
        end
      end
      ST_LOAD: begin
        if (k_live) begin
          k    <= k + LW'(1);
          addr <= addr + stride;
        end else if (mod_done) begin
          k    <= '0;
          addr <= base;
          src  <= src0;
        end
      end
      ST_TURN: begin
        if (k_live) begin
          k    <= k + LW'(1);
          addr <= addr + stride;
          src  <= src_inc;
        end
      end
      ST_FETCH: res_value <= rd_wide[31:0];
      ST_CELL, ST_DONE: ;
      default: ;
    endcase
    if (state == ST_DONE && out_free) begin
      m_tdata <= res_value;
      m_tuser <= res_status;
    end
  end

  // Cell store: one port, one access per cycle.
  logic [VALUE_BITS-1:0] cell_store [DEPTH];
  logic                  st_re;

  assign st_re = ((state == ST_LOAD) && k_live) || ((state == ST_CELL) && !is_write);

  always_ff @(posedge clk) begin
    if (p2_v) begin
      cell_store[p2_addr] <= lbuf_rdata;
    end else if (state == ST_CELL && is_write) begin
      cell_store[addr] <= wv;
    end
    if (st_re) begin
      mem_rdata <= cell_store[addr];
    end
  end

  // Line buffer: filled in line order, read back in rotated order.
  logic [VALUE_BITS-1:0] line_buffer [LBUF_DEPTH];

  always_ff @(posedge clk) begin
    if (p1_v) begin
      line_buffer[p1_idx] <= mem_rdata;
    end
    if (state == ST_TURN && k_live) begin
      lbuf_rdata <= line_buffer[src];
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking regression for the matrix line rotator
// Drives cell writes, cell reads and row/column rotations through the input
// stream, predicts every result beat with a shadow copy of the matrix, and
// checks the result stream beat by beat under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
  import mlr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD = 500;
  localparam int unsigned PHASE_ITEMS = 175;
  localparam int unsigned NUM_PHASES = 8;

  typedef struct packed {
    op_t         op;
    logic [4:0]  line_idx;
    logic        dir;
    logic [7:0]  shift;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
  } mlr_op_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
  } mlr_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_DATA_W-1:0]    s_tdata = '0;
  logic [S_USER_W-1:0]    s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_DATA_W-1:0]    m_tdata;
  logic [M_USER_W-1:0]    m_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow of the block: matrix contents and the raw size registers.
  logic [31:0] shadow_cells [0:15][0:15];
  logic [4:0]  shadow_rows = NUM_ROWS_RESET;
  logic [4:0]  shadow_cols = NUM_COLS_RESET;
  // Cells that the stimulus has written, so nothing unwritten is ever read.
  bit          cell_written [0:15][0:15];

  mlr_op_t     op_backlog[$];
  mlr_result_t awaited_results[$];
  mlr_op_t     in_flight;
  int unsigned items_issued = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  bit          quiet_phase = 1'b0;

  matrix_line_rotator DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned used_size(input logic [4:0] raw);
    if (raw == 0) return 1;
    if (raw > 16) return 16;
    return raw;
  endfunction

  function automatic mlr_result_t apply_op(input mlr_op_t t);
    mlr_result_t r;
    int unsigned nr, nc, n, lines, s, k, src, li;
    bit along_row;
    logic [31:0] lbuf [0:15];
    r.status = STATUS_OK;
    r.value = '0;
    nr = used_size(shadow_rows);
    nc = used_size(shadow_cols);
    case (t.op)
      OP_WRITE_CELL, OP_READ_CELL: begin
        if (t.row >= nr || t.col >= nc) begin
          r.status = STATUS_BAD_CELL;
        end else if (t.op == OP_WRITE_CELL) begin
          shadow_cells[t.row][t.col] = t.value;
        end else begin
          r.value = shadow_cells[t.row][t.col];
        end
      end
      default: begin
        along_row = (t.op == OP_ROTATE_ROW);
        lines = along_row ? nr : nc;
        n = along_row ? nc : nr;
        if (t.line_idx == 0 || t.line_idx > lines) begin
          r.status = STATUS_BAD_LINE;
        end else begin
          li = t.line_idx - 1;
          s = t.shift % n;
          for (k = 0; k < n; k++)
            lbuf[k] = along_row ? shadow_cells[li][k] : shadow_cells[k][li];
          // Right or down moves cell k to k + s; left or up moves it to k - s.
          for (k = 0; k < n; k++) begin
            src = t.dir ? (k + s) % n : (k + n - s) % n;
            if (along_row) shadow_cells[li][k] = lbuf[src];
            else shadow_cells[k][li] = lbuf[src];
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic mlr_op_t make_op(input op_t op, input logic [4:0] line_idx,
                                      input logic dir, input logic [7:0] shift,
                                      input logic [3:0] row, input logic [3:0] col,
                                      input logic [31:0] value);
    mlr_op_t t;
    t.op = op;
    t.line_idx = line_idx;
    t.dir = dir;
    t.shift = shift;
    t.row = row;
    t.col = col;
    t.value = value;
    return t;
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic mlr_op_t random_item();
    return make_op(op_t'($urandom_range(0, 3)), 5'($urandom), 1'($urandom),
                   8'($urandom), 4'($urandom), 4'($urandom), random_value());
  endfunction

  task automatic queue_op(input mlr_op_t t);
    if (t.op == OP_WRITE_CELL && t.row < used_size(shadow_rows) &&
        t.col < used_size(shadow_cols))
      cell_written[t.row][t.col] = 1'b1;
    op_backlog.push_back(t);
    items_issued++;
  endtask

  task automatic ensure_written(input int unsigned r, input int unsigned c);
    mlr_op_t w;
    if (!cell_written[r][c]) begin
      w = random_item();
      w.op = OP_WRITE_CELL;
      w.row = 4'(r);
      w.col = 4'(c);
      queue_op(w);
    end
  endtask

  task automatic cover_line(input bit along_row, input int unsigned li);
    int unsigned n, k;
    n = along_row ? used_size(shadow_cols) : used_size(shadow_rows);
    for (k = 0; k < n; k++) begin
      if (along_row) ensure_written(li, k);
      else ensure_written(k, li);
    end
  endtask

  task automatic queue_random_op();
    mlr_op_t t;
    int unsigned nr, nc, pick, lines;
    bit bad, along_row;
    t = random_item();
    nr = used_size(shadow_rows);
    nc = used_size(shadow_cols);
    pick = $urandom_range(0, 99);
    bad = ($urandom_range(0, 9) == 0);
    if (pick < 45) begin
      t.op = ($urandom_range(0, 1) == 0) ? OP_ROTATE_ROW : OP_ROTATE_COL;
      along_row = (t.op == OP_ROTATE_ROW);
      lines = along_row ? nr : nc;
      if ($urandom_range(0, 3) == 0) t.shift = 8'($urandom_range(0, 17));
      if (bad) begin
        t.line_idx = ($urandom_range(0, 1) == 0) ? 5'd0 :
                     5'($urandom_range(lines + 1, 31));
      end else begin
        t.line_idx = 5'($urandom_range(1, lines));
        cover_line(along_row, t.line_idx - 1);
      end
    end else begin
      t.op = (pick < 75) ? OP_READ_CELL : OP_WRITE_CELL;
      if (bad && (nr < 16 || nc < 16)) begin
        if (nr < 16 && (nc == 16 || $urandom_range(0, 1) == 0)) begin
          t.row = 4'($urandom_range(nr, 15));
        end else begin
          t.col = 4'($urandom_range(nc, 15));
        end
      end else begin
        t.row = 4'($urandom_range(0, nr - 1));
        t.col = 4'($urandom_range(0, nc - 1));
        if (t.op == OP_READ_CELL) ensure_written(t.row, t.col);
      end
    end
    queue_op(t);
  endtask

  task automatic settle();
    wait (results_seen == items_issued);
    @(posedge clk);
  endtask

  task automatic set_sizes(input logic [4:0] rows, input logic [4:0] cols);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_NUM_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    cfg_index <= REG_NUM_COLS;
    cfg_data <= cols;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_rows = rows;
    shadow_cols = cols;
  endtask

  // Input side: one beat per item from the backlog, a random gap after each outside the quiet phases.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) awaited_results.push_back(apply_op(in_flight));
      if (tx_gap != 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (op_backlog.size() != 0) begin
        in_flight = op_backlog.pop_front();
        s_tdata <= {2'b00, in_flight.value, in_flight.col, in_flight.row,
                    in_flight.shift, in_flight.dir, in_flight.line_idx};
        s_tuser <= in_flight.op;
        s_tvalid <= 1'b1;
        tx_gap = quiet_phase ? 0 : $urandom_range(0, 8);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side: check each beat, then stall for a random number of cycles outside the quiet phases.
  always @(posedge clk) begin
    mlr_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, status %0d value %h",
                   $time, m_tuser, m_tdata);
        end else begin
          want = awaited_results.pop_front();
          if (m_tuser !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          end
          if (m_tdata !== want.value) begin
            errors++;
            $display("%0t: read value expected %h actual %h", $time, want.value, m_tdata);
          end
        end
        rx_stall = quiet_phase ? 0 : $urandom_range(0, 8);
        // Long hold-offs let the block fill up and back-pressure the input.
        if (results_seen == 100 || results_seen == 900) rx_stall = LONG_HOLD;
      end else if (rx_stall != 0) begin
        rx_stall--;
      end
      m_tready <= (rx_stall == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [4:0] phase_rows [0:NUM_PHASES-1];
    logic [4:0] phase_cols [0:NUM_PHASES-1];
    int unsigned p, i;
    phase_rows = '{5'd0, 5'd16, 5'd1, 5'd31, 5'd17, 5'd5, 5'd0, 5'd0};
    phase_cols = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd0, 5'd11, 5'd0, 5'd0};
    phase_rows[6] = 5'($urandom_range(0, 31));
    phase_cols[6] = 5'($urandom_range(0, 31));
    phase_rows[7] = 5'($urandom_range(0, 31));
    phase_cols[7] = 5'($urandom_range(0, 31));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes: value extremes at the corners, read back, then bad line indexes.
    queue_op(make_op(OP_WRITE_CELL, 5'd31, 1'b1, 8'hff, 4'd0, 4'd0, 32'h8000_0000));
    queue_op(make_op(OP_WRITE_CELL, 5'd0, 1'b0, 8'h00, 4'd15, 4'd15, 32'h7fff_ffff));
    queue_op(make_op(OP_WRITE_CELL, 5'd31, 1'b1, 8'hff, 4'd0, 4'd15, 32'h0000_0000));
    queue_op(make_op(OP_WRITE_CELL, 5'd0, 1'b0, 8'h00, 4'd15, 4'd0, 32'hffff_ffff));
    queue_op(make_op(OP_READ_CELL, 5'd31, 1'b1, 8'hff, 4'd0, 4'd0, 32'hffff_ffff));
    queue_op(make_op(OP_READ_CELL, 5'd0, 1'b0, 8'h00, 4'd15, 4'd15, 32'h0000_0000));
    queue_op(make_op(OP_READ_CELL, 5'd31, 1'b1, 8'hff, 4'd0, 4'd15, 32'hffff_ffff));
    queue_op(make_op(OP_READ_CELL, 5'd0, 1'b0, 8'h00, 4'd15, 4'd0, 32'h0000_0000));
    queue_op(make_op(OP_ROTATE_ROW, 5'd0, 1'b0, 8'd1, 4'd15, 4'd15, 32'hffff_ffff));
    queue_op(make_op(OP_ROTATE_ROW, 5'd17, 1'b1, 8'd1, 4'd0, 4'd0, 32'h0));
    queue_op(make_op(OP_ROTATE_COL, 5'd31, 1'b0, 8'd255, 4'd0, 4'd0, 32'h0));
    queue_op(make_op(OP_ROTATE_COL, 5'd0, 1'b1, 8'd3, 4'd7, 4'd7, 32'h1234_5678));
    settle();

    // A 2 by 3 matrix: bad cells, then turns in both directions and by
    // shifts below, at and above the line length.
    set_sizes(5'd2, 5'd3);
    queue_op(make_op(OP_WRITE_CELL, 5'd1, 1'b0, 8'd0, 4'd2, 4'd0, 32'hdead_beef));
    queue_op(make_op(OP_READ_CELL, 5'd1, 1'b0, 8'd0, 4'd0, 4'd3, 32'h0));
    queue_op(make_op(OP_READ_CELL, 5'd1, 1'b0, 8'd0, 4'd15, 4'd15, 32'h0));
    cover_line(1'b1, 0);
    cover_line(1'b1, 1);
    queue_op(make_op(OP_ROTATE_ROW, 5'd1, 1'b0, 8'd1, 4'd0, 4'd0, 32'h0));
    queue_op(make_op(OP_ROTATE_ROW, 5'd2, 1'b1, 8'd255, 4'd0, 4'd0, 32'h0));
    queue_op(make_op(OP_ROTATE_COL, 5'd3, 1'b0, 8'd1, 4'd0, 4'd0, 32'h0));
    queue_op(make_op(OP_ROTATE_COL, 5'd1, 1'b1, 8'd2, 4'd0, 4'd0, 32'h0));
    queue_op(make_op(OP_ROTATE_COL, 5'd2, 1'b1, 8'd255, 4'd0, 4'd0, 32'h0));
    queue_op(make_op(OP_ROTATE_ROW, 5'd3, 1'b0, 8'd1, 4'd0, 4'd0, 32'h0));
    queue_op(make_op(OP_ROTATE_COL, 5'd4, 1'b1, 8'd1, 4'd0, 4'd0, 32'h0));
    queue_op(make_op(OP_READ_CELL, 5'd0, 1'b0, 8'd0, 4'd1, 4'd2, 32'h0));
    queue_op(make_op(OP_READ_CELL, 5'd0, 1'b0, 8'd0, 4'd0, 4'd0, 32'h0));
    settle();

    for (p = 0; p < NUM_PHASES; p++) begin
      set_sizes(phase_rows[p], phase_cols[p]);
      quiet_phase = (p % 3 == 2);
      for (i = 0; i < PHASE_ITEMS; i++) queue_random_op();
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
